// ===== hw/rtl/cbsd_pkg.sv =====
package cbsd_pkg;

  // Default number of stack entries for open arrays and maps.
  localparam int unsigned MAX_DEPTH_DEF = 64;

  // Reset value of the max_depth register.
  localparam logic [6:0] MAX_DEPTH_RST = 7'd64;

  // Major types.
  localparam logic [2:0] MT_NEG    = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_TAG    = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  // Additional values in the low bits of a head byte.
  localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
  localparam logic [4:0] AI_RSVD_LO   = 5'd28;
  localparam logic [4:0] AI_INDEF     = 5'd31;
  localparam logic [4:0] AI_FALSE     = 5'd20;
  localparam logic [4:0] AI_NULL      = 5'd22;

  // Byte roles.
  localparam logic [1:0] ROLE_HEAD = 2'd0;
  localparam logic [1:0] ROLE_ARG  = 2'd1;
  localparam logic [1:0] ROLE_PAY  = 2'd2;
  localparam logic [1:0] ROLE_DISC = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_INDEF  = 3'd1;
  localparam logic [2:0] ERR_RSVD   = 3'd2;
  localparam logic [2:0] ERR_TAG    = 3'd3;
  localparam logic [2:0] ERR_SIMPLE = 3'd4;
  localparam logic [2:0] ERR_DEPTH  = 3'd5;
  localparam logic [2:0] ERR_TRUNC  = 3'd6;
  localparam logic [2:0] ERR_NEGR   = 3'd7;

  // Decoder phase within the byte stream.
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_ARG,
    PH_PAY,
    PH_DRAIN
  } phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLOSE,
    ST_FILL,
    ST_EMIT
  } state_t;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [1:0]  byte_role;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic        head_done;
    logic        item_done;
    logic        top_done;
    logic [6:0]  nesting_level;
    logic [2:0]  error_code;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic decode;
    logic close;
    logic fill;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close_req;
    logic close_done;
    logic close_fill;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/cbsd_ctrl.sv =====
module cbsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cbsd_pkg::sts_t sts,
  output cbsd_pkg::cmd_t cmd
);
  import cbsd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.close_req ? ST_CLOSE : ST_EMIT;
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        if (sts.close_done) begin
          state_nxt = ST_EMIT;
        end else if (sts.close_fill) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = ST_CLOSE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/cbsd_dp.sv =====
module cbsd_dp #(
  parameter int unsigned MAX_DEPTH = cbsd_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbsd_pkg::cmd_t     cmd,
  output cbsd_pkg::sts_t     sts,
  input  cbsd_pkg::in_req_t  in_data,
  input  logic               cfg_valid,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbsd_pkg::out_res_t out_data
);
  import cbsd_pkg::*;

  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned EW = 66;

  // Stack memory of the entries below the cached top of stack.
  logic [EW-1:0] mem [MAX_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data_r;

  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  argl_r, argl_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic [LW-1:0] open_r, open_nxt;
  logic [63:0] tos_cnt_r, tos_cnt_nxt;
  logic        tos_map_r, tos_map_nxt;
  logic        tos_vn_r, tos_vn_nxt;
  logic [6:0]  maxd_r, maxd_nxt;
  out_res_t    res_r, res_nxt;
  out_res_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [4:0]  addl;
  logic [2:0]  mt;
  logic        fh_go;
  logic [2:0]  fh_major;
  logic [63:0] fh_arg;
  logic [63:0] acc_new;
  logic [3:0]  argl_dec;
  logic [63:0] pay_dec;
  logic [63:0] cnt_dec;
  out_res_t    fin;

  assign addl = byte_r[4:0];
  assign mt   = byte_r[7:5];

  always_comb begin
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    argl_nxt      = argl_r;
    pay_nxt       = pay_r;
    open_nxt      = open_r;
    tos_cnt_nxt   = tos_cnt_r;
    tos_map_nxt   = tos_map_r;
    tos_vn_nxt    = tos_vn_r;
    maxd_nxt      = maxd_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = AW'(open_r - LW'(1));
    mem_wd        = {tos_cnt_r, tos_map_r, tos_vn_r};
    rd_addr       = AW'(open_r - LW'(2));
    sts           = '0;
    fh_go         = 1'b0;
    fh_major      = mt;
    fh_arg        = 64'(addl);
    acc_new       = {acc_r[55:0], byte_r};
    argl_dec      = (argl_r != 4'd0) ? argl_r - 4'd1 : 4'd0;
    pay_dec       = (pay_r != 64'd0) ? pay_r - 64'd1 : 64'd0;
    cnt_dec       = tos_cnt_r - 64'd1;
    fin           = res_r;

    sts.out_free = !out_valid_r || !out_stall;

    // Register write; the user must do it only while idle, unchecked here.
    if (cfg_valid) begin
      maxd_nxt = cfg_data;
    end

    // Capture an accepted request.
    if (cmd.cap) begin
      byte_nxt = in_data.in_byte;
      last_nxt = in_data.in_last;
    end

    // Classify the byte and finish a head where one completes.
    if (cmd.decode) begin
      res_nxt = '0;
      if (phase_r == PH_DRAIN) begin
        res_nxt.byte_role = ROLE_DISC;
      end else begin
        res_nxt.nesting_level = 7'(open_r);
        unique case (phase_r)
          PH_HEAD: begin
            res_nxt.byte_role  = ROLE_HEAD;
            res_nxt.major_type = mt;
            priority if (32'(open_r) > 32'(maxd_r)) begin
              res_nxt.error_code = ERR_DEPTH;
            end else if (addl == AI_INDEF) begin
              res_nxt.error_code = ERR_INDEF;
            end else if (mt == MT_TAG) begin
              res_nxt.error_code = ERR_TAG;
            end else if (mt == MT_SIMPLE) begin
              if (addl >= AI_FALSE && addl <= AI_NULL) begin
                fh_go = 1'b1;
              end else begin
                res_nxt.error_code = ERR_SIMPLE;
              end
            end else if (addl >= AI_RSVD_LO) begin
              res_nxt.error_code = ERR_RSVD;
            end else if (addl < AI_ONE_BYTE) begin
              fh_go = 1'b1;
            end else begin
              pend_nxt  = mt;
              acc_nxt   = 64'd0;
              argl_nxt  = 4'b0001 << addl[1:0];
              phase_nxt = PH_ARG;
            end
          end
          PH_ARG: begin
            res_nxt.byte_role  = ROLE_ARG;
            res_nxt.major_type = pend_r;
            acc_nxt            = acc_new;
            argl_nxt           = argl_dec;
            if (argl_dec == 4'd0) begin
              fh_go    = 1'b1;
              fh_major = pend_r;
              fh_arg   = acc_new;
            end
          end
          PH_PAY: begin
            res_nxt.byte_role  = ROLE_PAY;
            res_nxt.major_type = pend_r;
            pay_nxt            = pay_dec;
            if (pay_dec == 64'd0) begin
              phase_nxt         = PH_HEAD;
              res_nxt.item_done = 1'b1;
              sts.close_req     = 1'b1;
            end
          end
          default: ;
        endcase

        // Head done: error, start a string, open a container or end item.
        if (fh_go) begin
          res_nxt.head_done = 1'b1;
          res_nxt.argument  = fh_arg;
          phase_nxt         = PH_HEAD;
          priority if (fh_major == MT_NEG && fh_arg[63]) begin
            res_nxt.error_code = ERR_NEGR;
          end else if ((fh_major == MT_BYTES || fh_major == MT_TEXT) && fh_arg != 64'd0) begin
            pend_nxt  = fh_major;
            pay_nxt   = fh_arg;
            phase_nxt = PH_PAY;
          end else if ((fh_major == MT_ARRAY || fh_major == MT_MAP) && fh_arg != 64'd0) begin
            if (32'(open_r) >= MAX_DEPTH) begin
              res_nxt.error_code = ERR_DEPTH;
            end else begin
              mem_we      = (open_r != LW'(0));
              tos_cnt_nxt = fh_arg;
              tos_map_nxt = (fh_major == MT_MAP);
              tos_vn_nxt  = 1'b0;
              open_nxt    = open_r + LW'(1);
            end
          end else begin
            res_nxt.item_done = 1'b1;
            sts.close_req     = 1'b1;
          end
        end
      end
    end

    // One step of closing finished containers.
    if (cmd.close) begin
      if (open_r == LW'(0)) begin
        res_nxt.top_done = 1'b1;
        sts.close_done   = 1'b1;
      end else if (tos_map_r && !tos_vn_r) begin
        tos_vn_nxt     = 1'b1;
        sts.close_done = 1'b1;
      end else begin
        tos_vn_nxt  = 1'b0;
        tos_cnt_nxt = cnt_dec;
        if (cnt_dec != 64'd0) begin
          sts.close_done = 1'b1;
        end else begin
          open_nxt = open_r - LW'(1);
          if (open_r == LW'(1)) begin
            res_nxt.top_done = 1'b1;
            sts.close_done   = 1'b1;
          end else begin
            sts.close_fill = 1'b1;
          end
        end
      end
    end

    // Reload the top of stack from memory after a pop.
    if (cmd.fill) begin
      {tos_cnt_nxt, tos_map_nxt, tos_vn_nxt} = rd_data_r;
    end

    // Final checks, hand the result to the output register, restart if due.
    if (cmd.emit) begin
      if (fin.byte_role != ROLE_DISC && fin.error_code == ERR_NONE && last_r &&
          !fin.top_done) begin
        fin.error_code = ERR_TRUNC;
      end
      out_nxt       = fin;
      out_valid_nxt = 1'b1;
      if (fin.error_code != ERR_NONE || last_r) begin
        open_nxt  = '0;
        phase_nxt = last_r ? PH_HEAD : PH_DRAIN;
        pend_nxt  = 3'd0;
        acc_nxt   = 64'd0;
        argl_nxt  = 4'd0;
        pay_nxt   = 64'd0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      open_r      <= '0;
      maxd_r      <= MAX_DEPTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      open_r      <= open_nxt;
      maxd_r      <= maxd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    pend_r    <= pend_nxt;
    acc_r     <= acc_nxt;
    argl_r    <= argl_nxt;
    pay_r     <= pay_nxt;
    tos_cnt_r <= tos_cnt_nxt;
    tos_map_r <= tos_map_nxt;
    tos_vn_r  <= tos_vn_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Stack memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/cbor_stream_decoder_core.sv =====
// Streaming checker for definite-length CBOR, one byte per request.
// Input channel: in_valid / in_stall with in_data (byte and last flag). The
// block stalls the input while it works on a byte and accepts the next one
// as soon as that byte's result sits in the output register.
// Result channel: out_valid / out_stall with out_data, one result per byte:
// its role, major type, argument, head, item and top-level completion flags,
// nesting level and error code.
// Configuration: cfg_valid / cfg_ready writes max_depth from cfg_data; it is
// always ready; the user must write it only while the block is idle (unchecked).
// Sequence: for most bytes the result is decoded, then registered at the
// output. Ending an item adds a walk of the nesting stack, plus a fill step
// for each finished array or map popped while an enclosing one stays open,
// since the next stack entry comes from a memory with a registered read.
// A new byte is accepted only once the last one's result has been emitted.
// Reset: synchronous, active low; the stack is empty, max_depth is 64 and
// no result is pending.
// When the receiver stalls, the result holds in the output register; one
// more byte may be decoded and then waits until the register frees up.
module cbor_stream_decoder_core #(
  parameter int unsigned MAX_DEPTH = cbsd_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbsd_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbsd_pkg::out_res_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import cbsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer for decode, stack walk and output.
  cbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Decode state, nesting stack and output register.
  cbsd_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
